>>> hw/rtl/two_bank_timer_pool_macros.svh
// assertion macros for the timer pool
`ifndef TWO_BANK_TIMER_POOL_MACROS_SVH
`define TWO_BANK_TIMER_POOL_MACROS_SVH
`define TBTP_ASSERT_IMPL(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tbtp check failed");
`define TBTP_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tbtp check failed");
`endif

>>> hw/rtl/tbtp_pkg.sv
// shared types and constants of the timer pool
package tbtp_pkg;
    localparam logic [2:0] FN_ALLOC   = 3'd0;
    localparam logic [2:0] FN_START   = 3'd1;
    localparam logic [2:0] FN_STOP    = 3'd2;
    localparam logic [2:0] FN_RESTART = 3'd3;
    localparam logic [2:0] FN_MS_TICK = 3'd4;
    localparam logic [2:0] FN_S_TICK  = 3'd5;
    localparam logic [2:0] FN_SERVICE = 3'd6;
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_STOPPED = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;
    localparam logic [1:0] ST_RUNNING = 2'd3;
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;
    localparam logic [7:0] BANK_BIT  = 8'h80;
    localparam logic [6:0] SLOT_MASK = 7'h7f;
    localparam logic [15:0] SEC_LIMIT = 16'd60;
    localparam logic [9:0] MS_PER_S  = 10'd1000;
    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] interval_s;
        logic [15:0] interval_ms;
        logic        isr_mode;
        logic [7:0]  handle;
    } in_item_t;
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] timer_handle;
        logic       fired;
        logic       last;
    } out_item_t;
endpackage

>>> hw/rtl/tbtp_if.sv
// valid/ready channel interfaces of the timer pool
interface tbtp_in_if;
    import tbtp_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbtp_out_if;
    import tbtp_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/two_bank_timer_pool.sv
// two-bank periodic timer pool with a slot-serial sequencer
// channels: in (func, interval_s, interval_ms, isr_mode, handle) and out
// (status, timer_handle, fired, last), both valid/ready; an item is taken
// when valid and ready are high at a rising clock edge
// allocate walks its bank one slot a cycle, up to the last slot of the bank
// start, stop and restart pass S_SLOT, where start and restart use the shared adder, then S_EMIT
// a tick visits every slot of its bank, one slot a cycle while the receiver does not stall;
// an interrupt-mode slot that fires also passes S_ARM to re-arm; service walks both banks the same way
// the slot walk and the one shared 32-bit adder set the rate: a tick passes S_IDLE, one S_SCAN
// per slot, S_DONE and S_EMIT, and one S_ARM per fire that re-arms
// each interrupt-mode fire and each serviced slot is one result item with fired high; every
// input item ends with one closing result item that has last high
// in.ready is high only while the sequencer is idle
// a stalled receiver holds the sequencer in place: the result register
// waits and no slot state moves until the item is taken
// reset returns all slots to idle and clears both time counters
module two_bank_timer_pool #(
    parameter int SEC_SLOTS = 8,
    parameter int MS_SLOTS  = 8
) (
    input logic clk,
    input logic rst_n,
    tbtp_in_if.sink    in,
    tbtp_out_if.source out
);
    import tbtp_pkg::*;
`include "two_bank_timer_pool_macros.svh"

    localparam int NS = (SEC_SLOTS > 1) ? $clog2(SEC_SLOTS) : 1;
    localparam int NM = (MS_SLOTS > 1) ? $clog2(MS_SLOTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_ARM   = 6'b000100,
        S_SLOT  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  sec_st_reg [SEC_SLOTS];
    logic        sec_isr_reg [SEC_SLOTS];
    logic [15:0] sec_iv_reg [SEC_SLOTS];
    logic [31:0] sec_dl_reg [SEC_SLOTS];
    logic [1:0]  ms_st_reg [MS_SLOTS];
    logic        ms_isr_reg [MS_SLOTS];
    logic [16:0] ms_iv_reg [MS_SLOTS];
    logic [31:0] ms_dl_reg [MS_SLOTS];
    logic [31:0] now_s_reg, now_ms_reg;

    in_item_t    item_reg;
    logic        bank_reg;
    logic [6:0]  idx_reg;
    logic [31:0] prod_reg;
    out_item_t   res_reg;
    logic        res_valid_reg;

    logic        sel_sec;
    logic [NS-1:0] si;
    logic [NM-1:0] mi;
    logic [1:0]  cur_st;
    logic        cur_isr;
    logic [31:0] cur_dl, cur_iv, cur_now, sum;
    logic        bank_end;
    logic [6:0]  hslot;
    logic        hsec, hrange;

    assign in.ready  = (state_reg == S_IDLE);
    assign out.valid = res_valid_reg;
    assign out.data  = res_reg;

    assign hsec   = item_reg.handle[7];
    assign hslot  = item_reg.handle[6:0] & SLOT_MASK;
    assign hrange = hsec ? (hslot >= 7'(SEC_SLOTS)) : (hslot >= 7'(MS_SLOTS));

    always_comb
    begin
        sel_sec = bank_reg;
        si = idx_reg[NS-1:0];
        mi = idx_reg[NM-1:0];
        cur_st  = sel_sec ? sec_st_reg[si] : ms_st_reg[mi];
        cur_isr = sel_sec ? sec_isr_reg[si] : ms_isr_reg[mi];
        cur_dl  = sel_sec ? sec_dl_reg[si] : ms_dl_reg[mi];
        cur_iv  = sel_sec ? {16'd0, sec_iv_reg[si]} : {15'd0, ms_iv_reg[mi]};
        cur_now = sel_sec ? now_s_reg : now_ms_reg;
        sum     = cur_now + cur_iv;
        bank_end = sel_sec ? (idx_reg == 7'(SEC_SLOTS - 1)) : (idx_reg == 7'(MS_SLOTS - 1));
    end

    logic stall;
    assign stall = res_valid_reg && !out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
            now_s_reg <= '0;
            now_ms_reg <= '0;
            for (int i = 0; i < SEC_SLOTS; i++)
            begin
                sec_st_reg[i] <= ST_IDLE;
                sec_isr_reg[i] <= 1'b0;
                sec_iv_reg[i] <= '0;
                sec_dl_reg[i] <= '0;
            end
            for (int i = 0; i < MS_SLOTS; i++)
            begin
                ms_st_reg[i] <= ST_IDLE;
                ms_isr_reg[i] <= 1'b0;
                ms_iv_reg[i] <= '0;
                ms_dl_reg[i] <= '0;
            end
        end
        else
        begin
            if (res_valid_reg && out.ready)
                res_valid_reg <= 1'b0;
            if (!stall)
            begin
                state_reg <= state_next;
                case (state_reg)
                    S_IDLE:
                    begin
                        if (in.valid)
                        begin
                            item_reg <= in.data;
                            idx_reg <= (in.data.func == FN_START || in.data.func == FN_STOP
                                || in.data.func == FN_RESTART) ? in.data.handle[6:0] : 7'd0;
                            prod_reg <= 32'(in.data.interval_s) * 32'(MS_PER_S);
                            case (in.data.func)
                                FN_ALLOC: bank_reg <= (in.data.interval_ms == 16'd0)
                                    || (in.data.interval_s > SEC_LIMIT);
                                FN_MS_TICK:
                                begin
                                    bank_reg <= 1'b0;
                                    now_ms_reg <= now_ms_reg + 32'd1;
                                end
                                FN_S_TICK:
                                begin
                                    bank_reg <= 1'b1;
                                    now_s_reg <= now_s_reg + 32'd1;
                                end
                                FN_SERVICE: bank_reg <= 1'b1;
                                default: bank_reg <= in.data.handle[7];
                            endcase
                        end
                    end
                    S_SCAN:
                    begin
                        case (item_reg.func)
                            FN_ALLOC:
                            begin
                                if (cur_st == ST_IDLE)
                                begin
                                    if (sel_sec)
                                    begin
                                        sec_st_reg[si] <= ST_STOPPED;
                                        sec_isr_reg[si] <= item_reg.isr_mode;
                                        sec_iv_reg[si] <= item_reg.interval_s;
                                    end
                                    else
                                    begin
                                        ms_st_reg[mi] <= ST_STOPPED;
                                        ms_isr_reg[mi] <= item_reg.isr_mode;
                                        ms_iv_reg[mi] <= 17'(prod_reg + 32'(item_reg.interval_ms));
                                    end
                                    res_reg <= '{STAT_OK, {sel_sec, idx_reg}, 1'b0, 1'b1};
                                    res_valid_reg <= 1'b1;
                                end
                                else if (bank_end)
                                begin
                                    res_reg <= '{STAT_NO_SLOT, 8'd0, 1'b0, 1'b1};
                                    res_valid_reg <= 1'b1;
                                end
                                else
                                    idx_reg <= idx_reg + 7'd1;
                            end
                            default:
                            begin
                                if (item_reg.func == FN_SERVICE ? (cur_st == ST_RUNNING)
                                    : (cur_now >= cur_dl && cur_st == ST_WAITING))
                                begin
                                    if (item_reg.func == FN_SERVICE || cur_isr)
                                    begin
                                        res_reg <= '{STAT_OK, {sel_sec, idx_reg}, 1'b1, 1'b0};
                                        res_valid_reg <= 1'b1;
                                    end
                                    else if (sel_sec)
                                        sec_st_reg[si] <= ST_RUNNING;
                                    else
                                        ms_st_reg[mi] <= ST_RUNNING;
                                end
                                if (state_next == S_SCAN)
                                begin
                                    if (bank_end)
                                    begin
                                        bank_reg <= 1'b0;
                                        idx_reg <= '0;
                                    end
                                    else
                                        idx_reg <= idx_reg + 7'd1;
                                end
                            end
                        endcase
                    end
                    S_ARM:
                    begin
                        if (sel_sec)
                        begin
                            sec_dl_reg[si] <= sum;
                            sec_st_reg[si] <= ST_WAITING;
                        end
                        else
                        begin
                            ms_dl_reg[mi] <= sum;
                            ms_st_reg[mi] <= ST_WAITING;
                        end
                        if (bank_end)
                        begin
                            bank_reg <= 1'b0;
                            idx_reg <= '0;
                        end
                        else
                            idx_reg <= idx_reg + 7'd1;
                    end
                    S_SLOT:
                    begin
                        if (!hrange)
                        begin
                            if (item_reg.func == FN_STOP)
                            begin
                                if (sel_sec) sec_st_reg[si] <= ST_IDLE;
                                else ms_st_reg[mi] <= ST_IDLE;
                            end
                            else if (sel_sec)
                            begin
                                sec_dl_reg[si] <= sum;
                                if (item_reg.func == FN_START)
                                    sec_st_reg[si] <= ST_WAITING;
                            end
                            else
                            begin
                                ms_dl_reg[mi] <= sum;
                                if (item_reg.func == FN_START)
                                    ms_st_reg[mi] <= ST_WAITING;
                            end
                        end
                        res_reg <= '{hrange ? STAT_RANGE : STAT_OK, item_reg.handle, 1'b0, 1'b1};
                        res_valid_reg <= 1'b1;
                    end
                    S_DONE:
                    begin
                        res_reg <= '{STAT_OK, 8'd0, 1'b0, 1'b1};
                        res_valid_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    logic scan_last;
    assign scan_last = bank_end && (item_reg.func != FN_SERVICE || !bank_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in.valid)
                begin
                    case (in.data.func)
                        FN_ALLOC, FN_MS_TICK, FN_S_TICK, FN_SERVICE: state_next = S_SCAN;
                        FN_START, FN_STOP, FN_RESTART: state_next = S_SLOT;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (item_reg.func == FN_ALLOC)
                begin
                    if (cur_st == ST_IDLE || bank_end)
                        state_next = S_EMIT;
                end
                else if ((item_reg.func == FN_SERVICE ? (cur_st == ST_RUNNING)
                    : (cur_now >= cur_dl && cur_st == ST_WAITING))
                    && (item_reg.func == FN_SERVICE || cur_isr))
                    state_next = S_ARM;
                else if (scan_last)
                    state_next = S_DONE;
            end
            S_ARM: state_next = scan_last ? S_DONE : S_SCAN;
            S_SLOT: state_next = S_EMIT;
            S_DONE: state_next = S_EMIT;
            S_EMIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    `TBTP_ASSERT_IMPL(a_ready_idle, in.ready, !res_valid_reg || state_reg == S_IDLE)
    `TBTP_ASSERT_NEXT(a_take_busy, in.valid && in.ready, !in.ready)
    `TBTP_ASSERT_IMPL(a_emit_valid, state_reg == S_EMIT, res_valid_reg && res_reg.last)
endmodule

>>> test/tb_two_bank_timer_pool.sv
// testbench of the two-bank timer pool: directed table, then random items against a predictor
module tb_two_bank_timer_pool;
    import tbtp_pkg::*;

    localparam int SEC_N = 8;
    localparam int MS_N = 8;
    localparam int N_RANDOM = 100;
    localparam int CALM_TAIL = 20;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tbtp_in_if  in_ch();
    tbtp_out_if out_ch();

    two_bank_timer_pool #(.SEC_SLOTS(SEC_N), .MS_SLOTS(MS_N)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [1:0]  sec_st[SEC_N];
    logic        sec_isr[SEC_N];
    logic [15:0] sec_ivl[SEC_N];
    logic [31:0] sec_dl[SEC_N];
    logic [1:0]  ms_st[MS_N];
    logic        ms_isr[MS_N];
    logic [16:0] ms_ivl[MS_N];
    logic [31:0] ms_dl[MS_N];
    logic [31:0] now_sec;
    logic [31:0] now_ms;

    out_item_t expected_q[$];
    out_item_t step_res[$];
    row_t      directed[$];
    int        errors = 0;
    bit        calm = 1'b0;
    bit        long_hold_req = 1'b0;
    int        out_hold = 0;
    int        idle_cycles = 0;

    function automatic out_item_t mk_res(logic [1:0] st, logic [7:0] h, logic f, logic l);
        out_item_t r;
        r.status = st;
        r.timer_handle = h;
        r.fired = f;
        r.last = l;
        return r;
    endfunction

    function automatic in_item_t mk_item(logic [2:0] fn, logic [15:0] s, logic [15:0] ms,
                                         logic isr, logic [7:0] h);
        in_item_t it;
        it.func = fn;
        it.interval_s = s;
        it.interval_ms = ms;
        it.isr_mode = isr;
        it.handle = h;
        return it;
    endfunction

    function automatic void pool_clear();
        for (int i = 0; i < SEC_N; i++)
        begin
            sec_st[i] = ST_IDLE;
            sec_isr[i] = 1'b0;
            sec_ivl[i] = '0;
            sec_dl[i] = '0;
        end
        for (int i = 0; i < MS_N; i++)
        begin
            ms_st[i] = ST_IDLE;
            ms_isr[i] = 1'b0;
            ms_ivl[i] = '0;
            ms_dl[i] = '0;
        end
        now_sec = '0;
        now_ms = '0;
    endfunction

    function automatic void pool_step(in_item_t it);
        logic        sec;
        int          slot;
        int          size;
        bit          found;
        logic [31:0] sum;
        step_res.delete();
        found = 1'b0;
        case (it.func)
            FN_ALLOC:
            begin
                if (it.interval_ms == 16'd0 || it.interval_s > SEC_LIMIT)
                begin
                    for (int i = 0; i < SEC_N && !found; i++)
                        if (sec_st[i] == ST_IDLE)
                        begin
                            sec_ivl[i] = it.interval_s;
                            sec_st[i] = ST_STOPPED;
                            sec_isr[i] = it.isr_mode;
                            step_res.push_back(mk_res(STAT_OK, 8'(i) | BANK_BIT, 1'b0, 1'b1));
                            found = 1'b1;
                        end
                end
                else
                begin
                    for (int i = 0; i < MS_N && !found; i++)
                        if (ms_st[i] == ST_IDLE)
                        begin
                            sum = 32'(it.interval_ms) + 32'(it.interval_s) * 32'(MS_PER_S);
                            ms_ivl[i] = sum[16:0];
                            ms_st[i] = ST_STOPPED;
                            ms_isr[i] = it.isr_mode;
                            step_res.push_back(mk_res(STAT_OK, 8'(i), 1'b0, 1'b1));
                            found = 1'b1;
                        end
                end
                if (!found)
                    step_res.push_back(mk_res(STAT_NO_SLOT, 8'd0, 1'b0, 1'b1));
            end
            FN_START, FN_STOP, FN_RESTART:
            begin
                sec = (it.handle & BANK_BIT) != 8'd0;
                slot = int'(it.handle[6:0] & SLOT_MASK);
                size = sec ? SEC_N : MS_N;
                if (slot >= size)
                    step_res.push_back(mk_res(STAT_RANGE, it.handle, 1'b0, 1'b1));
                else
                begin
                    if (it.func != FN_STOP)
                    begin
                        if (sec)
                            sec_dl[slot] = now_sec + 32'(sec_ivl[slot]);
                        else
                            ms_dl[slot] = now_ms + 32'(ms_ivl[slot]);
                    end
                    if (it.func == FN_START)
                    begin
                        if (sec) sec_st[slot] = ST_WAITING;
                        else ms_st[slot] = ST_WAITING;
                    end
                    else if (it.func == FN_STOP)
                    begin
                        if (sec) sec_st[slot] = ST_IDLE;
                        else ms_st[slot] = ST_IDLE;
                    end
                    step_res.push_back(mk_res(STAT_OK, it.handle, 1'b0, 1'b1));
                end
            end
            FN_MS_TICK:
            begin
                now_ms = now_ms + 32'd1;
                for (int i = 0; i < MS_N; i++)
                    if (now_ms >= ms_dl[i] && ms_st[i] == ST_WAITING)
                    begin
                        ms_st[i] = ST_RUNNING;
                        if (ms_isr[i])
                        begin
                            step_res.push_back(mk_res(STAT_OK, 8'(i), 1'b1, 1'b0));
                            ms_dl[i] = now_ms + 32'(ms_ivl[i]);
                            ms_st[i] = ST_WAITING;
                        end
                    end
                step_res.push_back(mk_res(STAT_OK, 8'd0, 1'b0, 1'b1));
            end
            FN_S_TICK:
            begin
                now_sec = now_sec + 32'd1;
                for (int i = 0; i < SEC_N; i++)
                    if (now_sec >= sec_dl[i] && sec_st[i] == ST_WAITING)
                    begin
                        sec_st[i] = ST_RUNNING;
                        if (sec_isr[i])
                        begin
                            step_res.push_back(mk_res(STAT_OK, 8'(i) | BANK_BIT, 1'b1, 1'b0));
                            sec_dl[i] = now_sec + 32'(sec_ivl[i]);
                            sec_st[i] = ST_WAITING;
                        end
                    end
                step_res.push_back(mk_res(STAT_OK, 8'd0, 1'b0, 1'b1));
            end
            FN_SERVICE:
            begin
                for (int i = 0; i < SEC_N; i++)
                    if (sec_st[i] == ST_RUNNING)
                    begin
                        step_res.push_back(mk_res(STAT_OK, 8'(i) | BANK_BIT, 1'b1, 1'b0));
                        sec_dl[i] = now_sec + 32'(sec_ivl[i]);
                        sec_st[i] = ST_WAITING;
                    end
                for (int i = 0; i < MS_N; i++)
                    if (ms_st[i] == ST_RUNNING)
                    begin
                        step_res.push_back(mk_res(STAT_OK, 8'(i), 1'b1, 1'b0));
                        ms_dl[i] = now_ms + 32'(ms_ivl[i]);
                        ms_st[i] = ST_WAITING;
                    end
                step_res.push_back(mk_res(STAT_OK, 8'd0, 1'b0, 1'b1));
            end
            default:
                step_res.push_back(mk_res(STAT_OK, 8'd0, 1'b0, 1'b1));
        endcase
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        it.interval_s = 16'($urandom);
        it.interval_ms = 16'($urandom);
        it.isr_mode = 1'($urandom);
        it.handle = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            it.func = FN_ALLOC;
            if ($urandom_range(0, 5) != 0)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    it.interval_s = 16'($urandom_range(0, 3));
                    it.interval_ms = 16'd0;
                end
                else
                begin
                    it.interval_s = 16'd0;
                    it.interval_ms = 16'($urandom_range(1, 12));
                end
            end
        end
        else if (pick < 30)
            it.func = FN_START;
        else if (pick < 38)
            it.func = FN_STOP;
        else if (pick < 44)
            it.func = FN_RESTART;
        else if (pick < 74)
            it.func = FN_MS_TICK;
        else if (pick < 86)
            it.func = FN_S_TICK;
        else if (pick < 97)
            it.func = FN_SERVICE;
        else
            it.func = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 7) != 0)
            it.handle = ($urandom_range(0, 1) != 0 ? BANK_BIT : 8'd0) | 8'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic send_item(in_item_t it, bit typed, out_item_t tres);
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        pool_step(it);
        if (typed)
            expected_q.push_back(tres);
        else
            foreach (step_res[i])
                expected_q.push_back(step_res[i]);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 15);
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d handle=%h fired=%0d last=%0d",
                             $time, out_ch.data.status, out_ch.data.timer_handle,
                             out_ch.data.fired, out_ch.data.last);
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_q.pop_front();
                    if (out_ch.data.status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, out_ch.data.status);
                        errors++;
                    end
                    if (out_ch.data.timer_handle !== e.timer_handle)
                    begin
                        $display("%0t: timer_handle expected %h actual %h",
                                 $time, e.timer_handle, out_ch.data.timer_handle);
                        errors++;
                    end
                    if (out_ch.data.fired !== e.fired)
                    begin
                        $display("%0t: fired expected %0d actual %0d",
                                 $time, e.fired, out_ch.data.fired);
                        errors++;
                    end
                    if (out_ch.data.last !== e.last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, e.last, out_ch.data.last);
                        errors++;
                    end
                end
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_ch.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_hold = 300;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_hold = $urandom_range(0, 14);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        pool_clear();

        // typed rows: after reset, extremes, error codes
        directed.push_back('{mk_item(FN_MS_TICK, 0, 0, 0, 0), 1, mk_res(STAT_OK, 0, 0, 1)});
        directed.push_back('{mk_item(FN_ALLOC, 0, 0, 1, 0), 1, mk_res(STAT_OK, 8'h80, 0, 1)});
        directed.push_back('{mk_item(FN_ALLOC, 0, 5, 1, 0), 1, mk_res(STAT_OK, 8'h00, 0, 1)});
        directed.push_back('{mk_item(FN_ALLOC, 60, 16'hffff, 0, 0), 1,
                             mk_res(STAT_OK, 8'h01, 0, 1)});
        directed.push_back('{mk_item(FN_ALLOC, 16'hffff, 16'hffff, 0, 8'hff), 1,
                             mk_res(STAT_OK, 8'h81, 0, 1)});
        directed.push_back('{mk_item(FN_START, 0, 0, 0, 8'h7f), 1, mk_res(STAT_RANGE, 8'h7f, 0, 1)});
        directed.push_back('{mk_item(FN_START, 0, 0, 0, 8'hff), 1, mk_res(STAT_RANGE, 8'hff, 0, 1)});
        directed.push_back('{mk_item(FN_START, 0, 0, 0, 8'h00), 0, '0});
        directed.push_back('{mk_item(FN_START, 0, 0, 0, 8'h80), 0, '0});
        repeat (5) directed.push_back('{mk_item(FN_MS_TICK, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_item(FN_S_TICK, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_item(FN_START, 0, 0, 0, 8'h01), 0, '0});
        directed.push_back('{mk_item(FN_START, 0, 0, 0, 8'h81), 0, '0});
        directed.push_back('{mk_item(FN_RESTART, 0, 0, 0, 8'h00), 0, '0});
        directed.push_back('{mk_item(FN_S_TICK, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_item(FN_SERVICE, 0, 0, 0, 0), 0, '0});
        directed.push_back('{mk_item(FN_STOP, 0, 0, 0, 8'h80), 0, '0});
        directed.push_back('{mk_item(3'd7, 16'hffff, 16'hffff, 1, 8'hff), 1,
                             mk_res(STAT_OK, 0, 0, 1)});
        // fill the seconds bank, then one more
        repeat (7) directed.push_back('{mk_item(FN_ALLOC, 1, 0, 0, 0), 0, '0});
        directed.push_back('{mk_item(FN_ALLOC, 2, 0, 1, 0), 1, mk_res(STAT_NO_SLOT, 0, 0, 1)});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_item(directed[i].item, directed[i].typed, directed[i].res);
            sender_gap();
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 40)
                long_hold_req = 1'b1;
            if (n == 60)
            begin
                in_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_q.size() != 0);
            end
            if (n == N_RANDOM - CALM_TAIL)
                calm = 1'b1;
            send_item(random_item(), 1'b0, '0);
            sender_gap();
        end
        in_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> two_bank_timer_pool.f
+incdir+hw/rtl
hw/rtl/tbtp_pkg.sv
hw/rtl/tbtp_if.sv
hw/rtl/two_bank_timer_pool.sv
test/tb_two_bank_timer_pool.sv
